/* hdl/assert_macros.svh */
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked only while reset is released.
`define NPS_ASSERT(label, clk, rstn, prop) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) prop) \
        else $error("nps assertion failed");

// Checked on every edge, reset included.
`define NPS_ASSERT_ALWAYS(label, clk, prop) \
    label: assert property (@(posedge clk) prop) \
        else $error("nps assertion failed");

`endif

/* hdl/nps_pkg.sv */
// Shared constants, types and functions of the non-overlapping pattern search.
package nps_pkg;

    localparam int MAX_PATTERN = 16;
    localparam int LEN_W       = $clog2(MAX_PATTERN + 1);
    localparam int IDX_W       = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;
    localparam int SKIP_W      = 5;
    localparam int POS_W       = 32;
    localparam int CFG_W       = 64;
    localparam int CFG_IDX_W   = 2;
    localparam int PLEN_W      = 5;
    localparam int S_DATA_W    = 8;
    localparam int M_DATA_W    = 40;

    localparam logic [CFG_IDX_W-1:0] REG_PATTERN_LOW  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PATTERN_HIGH = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_PATTERN_LEN  = 2'd2;

    typedef struct packed {
        logic             found;
        logic [POS_W-1:0] match_start;
        logic             string_done;
    } result_t;

    function automatic logic [7:0] pattern_byte(input logic [2*CFG_W-1:0] pat,
                                                input logic [IDX_W-1:0]   idx);
        logic [7:0] b;
        b = pat[32'(idx) * 8 +: 8];
        return b;
    endfunction

endpackage

/* hdl/nonoverlap_pattern_search.sv */
// Non-overlapping pattern search, one text byte per cycle while s_tready is
// high. A row of 16 cells holds the most recent bytes and compares each
// against its pattern byte as the window shifts, so a byte is accepted every
// cycle while the output buffer has room; its result word is registered in
// the output buffer before it reaches the master side. Matches are reported on
// the byte where they end; the following length-1 bytes of the same string are
// blocked. A two-word output buffer keeps input flowing for one more byte
// while the master side stalls. Configuration writes take effect on the next
// byte; a length of zero never matches and lengths above 16 act as 16.
module nonoverlap_pattern_search (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              cfg_we,
    input  logic [nps_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [nps_pkg::CFG_W-1:0]         cfg_wdata,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [nps_pkg::S_DATA_W-1:0]      s_tdata,  // [7:0] text_byte
    input  logic                              s_tlast,  // final_byte
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [nps_pkg::M_DATA_W-1:0]      m_tdata,  // [0] found, [32:1] match_start
    output logic                              m_tlast   // string_done
);

    localparam int N = nps_pkg::MAX_PATTERN;

    logic [nps_pkg::CFG_W-1:0]    pat_low_reg, pat_high_reg;
    logic [nps_pkg::PLEN_W-1:0]   pat_len_reg;
    logic [nps_pkg::POS_W-1:0]    pos_reg, pos_next;
    logic [nps_pkg::SKIP_W-1:0]   skip_reg, skip_next;
    logic [nps_pkg::LEN_W-1:0]    used_len;
    logic [2*nps_pkg::CFG_W-1:0]  pat_vec;
    logic                         accept, hit;
    logic [7:0]                   chain_byte [N];
    logic [N-1:0]                 chain_valid;
    logic [N-1:0]                 cell_ok;
    nps_pkg::result_t             res;
    nps_pkg::result_t             out_res;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pat_low_reg  <= '0;
            pat_high_reg <= '0;
            pat_len_reg  <= nps_pkg::PLEN_W'(1);
        end else if (cfg_we) begin
            unique case (cfg_index)
                nps_pkg::REG_PATTERN_LOW:  pat_low_reg  <= cfg_wdata;
                nps_pkg::REG_PATTERN_HIGH: pat_high_reg <= cfg_wdata;
                nps_pkg::REG_PATTERN_LEN:  pat_len_reg  <= cfg_wdata[nps_pkg::PLEN_W-1:0];
                default: ;
            endcase
        end
    end

    assign pat_vec  = {pat_high_reg, pat_low_reg};
    assign used_len = (pat_len_reg > nps_pkg::PLEN_W'(N)) ? nps_pkg::LEN_W'(N)
                                                          : nps_pkg::LEN_W'(pat_len_reg);
    assign accept   = s_tvalid & s_tready;

    for (genvar k = 0; k < N; k++) begin : g_cell
        logic [nps_pkg::LEN_W-1:0] pidx;
        logic                      act;
        logic [7:0]                b_in;
        logic                      v_in;

        assign act  = nps_pkg::LEN_W'(k) < used_len;
        assign pidx = used_len - nps_pkg::LEN_W'(k) - nps_pkg::LEN_W'(1);

        if (k == 0) begin : g_head
            assign b_in = s_tdata[7:0];
            assign v_in = 1'b1;
        end else begin : g_body
            assign b_in = chain_byte[k-1];
            assign v_in = chain_valid[k-1];
        end

        nps_cell u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .shift     (accept),
            .flush     (s_tlast),
            .byte_in   (b_in),
            .valid_in  (v_in),
            .pat_byte  (nps_pkg::pattern_byte(pat_vec, pidx[nps_pkg::IDX_W-1:0])),
            .active    (act),
            .byte_out  (chain_byte[k]),
            .valid_out (chain_valid[k]),
            .match_ok  (cell_ok[k])
        );
    end

    assign hit = (skip_reg == '0) & (used_len != '0) & (&cell_ok);

    always_comb begin
        res.found       = hit;
        res.match_start = hit ? pos_reg - nps_pkg::POS_W'(used_len - nps_pkg::LEN_W'(1))
                              : '0;
        res.string_done = s_tlast;

        pos_next  = pos_reg + nps_pkg::POS_W'(1);
        skip_next = skip_reg;
        if (skip_reg != '0) begin
            skip_next = skip_reg - nps_pkg::SKIP_W'(1);
        end else if (hit) begin
            skip_next = nps_pkg::SKIP_W'(used_len - nps_pkg::LEN_W'(1));
        end
        if (s_tlast) begin
            pos_next  = '0;
            skip_next = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg  <= '0;
            skip_reg <= '0;
        end else if (accept) begin
            pos_reg  <= pos_next;
            skip_reg <= skip_next;
        end
    end

    nps_out_buf u_out_buf (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (accept),
        .push_data (res),
        .in_ready  (s_tready),
        .out_valid (m_tvalid),
        .out_data  (out_res),
        .out_ready (m_tready)
    );

    assign m_tdata = {(nps_pkg::M_DATA_W - nps_pkg::POS_W - 1)'(0),
                      out_res.match_start, out_res.found};
    assign m_tlast = out_res.string_done;

endmodule

/* hdl/nps_cell.sv */
// One window cell: holds a byte and its valid bit, compares the incoming byte.
module nps_cell (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       shift,
    input  logic       flush,
    input  logic [7:0] byte_in,
    input  logic       valid_in,
    input  logic [7:0] pat_byte,
    input  logic       active,
    output logic [7:0] byte_out,
    output logic       valid_out,
    output logic       match_ok
);

    logic [7:0] byte_reg;
    logic       valid_reg;

    always_ff @(posedge aclk) begin
        if (shift) begin
            byte_reg <= byte_in;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (shift) begin
            valid_reg <= valid_in & ~flush;
        end
    end

    // byte_in / valid_in are this cell's contents after the shift
    assign match_ok  = ~active | (valid_in & (byte_in == pat_byte));
    assign byte_out  = byte_reg;
    assign valid_out = valid_reg;

endmodule

/* hdl/nps_out_buf.sv */
// Two-word output buffer: main register plus skid register.
module nps_out_buf (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              push,
    input  nps_pkg::result_t  push_data,
    output logic              in_ready,
    output logic              out_valid,
    output nps_pkg::result_t  out_data,
    input  logic              out_ready
);

    logic             main_v_reg, main_v_next;
    logic             skid_v_reg, skid_v_next;
    nps_pkg::result_t main_reg, main_next;
    nps_pkg::result_t skid_reg, skid_next;
    logic             pop;

    assign pop = main_v_reg & out_ready;

    always_comb begin
        main_v_next = main_v_reg;
        skid_v_next = skid_v_reg;
        main_next   = main_reg;
        skid_next   = skid_reg;
        if (pop || !main_v_reg) begin
            main_v_next = skid_v_reg | push;
            main_next   = skid_v_reg ? skid_reg : push_data;
            skid_v_next = 1'b0;
        end else if (push) begin
            skid_v_next = 1'b1;
            skid_next   = push_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            main_v_reg <= 1'b0;
            skid_v_reg <= 1'b0;
        end else begin
            main_v_reg <= main_v_next;
            skid_v_reg <= skid_v_next;
        end
    end

    always_ff @(posedge aclk) begin
        main_reg <= main_next;
        skid_reg <= skid_next;
    end

    assign in_ready  = ~skid_v_reg;
    assign out_valid = main_v_reg;
    assign out_data  = main_reg;

endmodule

/* hdl/nps_checker.sv */
// Port-level checker for the pattern search, bound to the top level.
`include "assert_macros.svh"

module nps_checker (
    input logic                          aclk,
    input logic                          aresetn,
    input logic                          s_tready,
    input logic                          m_tvalid,
    input logic                          m_tready,
    input logic [nps_pkg::M_DATA_W-1:0]  m_tdata
);

    `NPS_ASSERT(a_stall_holds_valid, aclk, aresetn, m_tvalid && !m_tready |=> m_tvalid)
    `NPS_ASSERT(a_no_hit_zero_start, aclk, aresetn, m_tvalid && !m_tdata[0] |-> m_tdata[32:1] == '0)
    `NPS_ASSERT(a_backpressure_only_when_full, aclk, aresetn, !s_tready |-> m_tvalid && !$past(m_tready))
    `NPS_ASSERT_ALWAYS(a_reset_clears_output, aclk, !aresetn |=> !m_tvalid && s_tready)

endmodule

bind nonoverlap_pattern_search nps_checker u_nps_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
